>>> hdl/tpq_pkg.sv
// Shared types, constants and codes for the toggle playlist queue.
package tpq_pkg;

  localparam int NUM_ALBUMS = 16;
  localparam int NUM_TRACKS = 16;
  localparam int LIST_DEPTH = 256;

  localparam int IDX_W   = $clog2(LIST_DEPTH);
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int COUNT_W = 9;
  localparam int PADDR_W = 3;

  localparam logic [6:0] ALBUM_LIMIT = 7'(NUM_ALBUMS);
  localparam logic [6:0] TRACK_LIMIT = 7'(NUM_TRACKS);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

  typedef enum logic [2:0] {
    FUNC_TOGGLE  = 3'd0,
    FUNC_NEXT    = 3'd1,
    FUNC_CLEAR   = 3'd2,
    FUNC_CHECK   = 3'd3,
    FUNC_RESTART = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_REMOVED = 2'd1,
    ST_APPENDED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [PADDR_W-3:0] REG_AUTOSWITCH = '0;

  typedef struct packed {
    logic [3:0] album;
    logic [3:0] track;
  } entry_t;

  // Control word broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift;
    logic             wr;
    logic [IDX_W-1:0] wpos;
    entry_t           wdata;
  } tpq_ctl_t;

endpackage

>>> hdl/tpq_cell.sv
// One playlist slot: takes its right neighbor on a shift, or a write at its own index.
module tpq_cell
  import tpq_pkg::*;
(
  input  logic             clk,
  input  tpq_ctl_t         ctl,
  input  logic [IDX_W-1:0] idx,
  input  entry_t           right,
  output entry_t           data
);

  always_ff @(posedge clk) begin
    if (ctl.wr && (idx == ctl.wpos)) begin
      data <= ctl.wdata;
    end else if (ctl.shift) begin
      data <= right;
    end
  end

endmodule

>>> hdl/tpq_chain.sv
// Row of playlist cells; entries move one slot toward the head on each shift.
module tpq_chain
  import tpq_pkg::*;
(
  input  logic     clk,
  input  tpq_ctl_t ctl,
  output entry_t   head
);

  entry_t slot [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    entry_t right;
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right = slot[0];
    end else begin : g_mid
      assign right = slot[i+1];
    end
    tpq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(i)),
      .right (right),
      .data  (slot[i])
    );
  end

  assign head = slot[0];

endmodule

>>> hdl/toggle_playlist_queue.sv
// Top level: sequencer over the cell chain, config register and output word register.
//
//  channel | signals                                             | direction
//  --------+-----------------------------------------------------+----------
//  in      | in_valid/in_ready, func, album, track, init,        | to block
//          |   ui_music_active                                   |
//  out     | out_valid/out_ready, status, stop_playback,         | from block
//          |   start_playback, play_album, play_track, entry_count|
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready | both
//
// A toggle rotates the whole list through the head cell, one entry a cycle. After the scan a
// removal or a full list finishes; an append writes the entry at the tail and, unless init is
// set, runs a check, which may rotate the list once before it plays the head. One word is in
// flight at a time; a new word is taken while the last result waits in the output register,
// and a finished word holds until that register frees. Reset empties the list, clears started,
// autoswitch and out_valid, and returns the sequencer to idle.
module toggle_playlist_queue
  import tpq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [3:0]         album,
  input  logic [3:0]         track,
  input  logic               init,
  input  logic               ui_music_active,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               stop_playback,
  output logic               start_playback,
  output logic [3:0]         play_album,
  output logic [3:0]         play_track,
  output logic [COUNT_W-1:0] entry_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_APPEND = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_ROT    = 7'b0010000,
    S_PLAY   = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  logic   autoswitch;
  logic   started;
  logic [CNT_W-1:0] length;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] remaining;
  logic   found;
  logic   found_head;
  entry_t op_entry;
  logic   op_init;
  logic   op_ui;
  status_t res_status;
  logic   res_stop;
  logic   res_start;
  entry_t res_play;

  tpq_ctl_t ctl;
  entry_t   head;
  logic     reg_sel;
  logic     cfg_wr;
  logic     head_match;
  logic     in_range;
  logic     out_free;

  tpq_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_AUTOSWITCH);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {31'b0, autoswitch} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      autoswitch <= 1'b0;
    end else if (cfg_wr) begin
      autoswitch <= pwdata[0];
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign out_free   = !out_valid || out_ready;
  assign head_match = (head == op_entry) && !found;
  assign in_range   = ({3'b0, album} < ALBUM_LIMIT) && ({3'b0, track} < TRACK_LIMIT);

  // Chain control
  always_comb begin
    ctl.shift = 1'b0;
    ctl.wr    = 1'b0;
    ctl.wpos  = '0;
    ctl.wdata = head;
    unique case (state)
      S_SCAN: begin
        // pop the head; push it back to the tail unless it is the first match
        if (remaining != '0) begin
          ctl.shift = 1'b1;
          ctl.wr    = !head_match;
          ctl.wpos  = IDX_W'(cur - 1'b1);
        end
      end
      S_APPEND: begin
        ctl.wr    = 1'b1;
        ctl.wpos  = IDX_W'(length);
        ctl.wdata = op_entry;
      end
      S_ROT: begin
        ctl.shift = 1'b1;
        ctl.wr    = 1'b1;
        ctl.wpos  = IDX_W'(length - 1'b1);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      started   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_entry   <= '{album: album, track: track};
            op_init    <= init;
            op_ui      <= ui_music_active;
            res_status <= ST_NONE;
            res_stop   <= (func == FUNC_CLEAR);
            res_start  <= 1'b0;
            res_play   <= '0;
            cur        <= length;
            remaining  <= length;
            found      <= 1'b0;
            found_head <= 1'b0;
            case (func)
              FUNC_TOGGLE: begin
                state <= in_range ? S_SCAN : S_FINISH;
              end
              FUNC_NEXT: begin
                state <= (length != '0) ? S_ROT : S_FINISH;
              end
              FUNC_CLEAR: begin
                length  <= '0;
                started <= 1'b0;
                state   <= S_FINISH;
              end
              FUNC_CHECK: begin
                state <= S_CHECK;
              end
              FUNC_RESTART: begin
                started <= 1'b0;
                state   <= S_FINISH;
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (remaining != '0) begin
            remaining <= remaining - 1'b1;
            if (head_match) begin
              found      <= 1'b1;
              found_head <= (remaining == length);
              cur        <= cur - 1'b1;
            end
          end else if (found) begin
            length     <= cur;
            res_status <= ST_REMOVED;
            if (found_head) begin
              started  <= 1'b0;
              res_stop <= 1'b1;
            end
            state <= S_FINISH;
          end else if (length == DEPTH_CNT) begin
            res_status <= ST_FULL;
            state      <= S_FINISH;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          length     <= length + 1'b1;
          res_status <= ST_APPENDED;
          state      <= op_init ? S_FINISH : S_CHECK;
        end
        S_CHECK: begin
          if (op_ui || (length == '0) || started) begin
            state <= S_FINISH;
          end else begin
            started <= 1'b1;
            if (autoswitch) begin
              state <= S_ROT;
            end else begin
              res_start <= 1'b1;
              res_play  <= head;
              state     <= S_FINISH;
            end
          end
        end
        S_ROT: begin
          state <= S_PLAY;
        end
        S_PLAY: begin
          res_start <= 1'b1;
          res_play  <= head;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      status         <= res_status;
      stop_playback  <= res_stop;
      start_playback <= res_start;
      play_album     <= res_play.album;
      play_track     <= res_play.track;
      entry_count    <= COUNT_W'(length);
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= DEPTH_CNT)
    else $error("list length beyond depth");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cur <= length) && (remaining <= cur))
    else $error("scan counters out of order");

  a_play_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_ROT) || (state == S_PLAY)) |-> (length != '0))
    else $error("rotate on empty list");

  a_stop_start: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stop_playback && start_playback))
    else $error("stop and start in one word");

endmodule

>>> tb/tb_toggle_playlist_queue.sv
// Self-checking testbench for the toggle playlist queue: directed table, then random phases.
module tb_toggle_playlist_queue;
  import tpq_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 16;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [PADDR_W-1:0] AUTOSWITCH_ADDR = {REG_AUTOSWITCH, 2'b00};

  typedef struct packed {
    logic [2:0] func;
    logic [3:0] album;
    logic [3:0] track;
    logic       init;
    logic       ui;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic               stop;
    logic               start;
    logic [3:0]         album;
    logic [3:0]         track;
    logic [COUNT_W-1:0] count;
  } resp_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  typed;
    resp_t want;
  } dir_row_t;

  localparam resp_t NO_WANT = '0;
  localparam int NUM_DIRECTED = 22;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{FUNC_CHECK,    4'd0,  4'd0,  1'b0, 1'b0}, 1'b1, '{ST_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_NEXT,     4'd0,  4'd0,  1'b0, 1'b0}, 1'b1, '{ST_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_RESTART,  4'd0,  4'd0,  1'b0, 1'b0}, 1'b1, '{ST_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_SPARE_LO, 4'd15, 4'd15, 1'b1, 1'b1}, 1'b1, '{ST_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_SPARE_HI, 4'd0,  4'd0,  1'b0, 1'b0}, 1'b1, '{ST_NONE, 1'b0, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_TOGGLE,   4'd0,  4'd0,  1'b0, 1'b0}, 1'b1,
      '{ST_APPENDED, 1'b0, 1'b1, 4'd0, 4'd0, 9'd1}},
    '{'{FUNC_TOGGLE,   4'd15, 4'd15, 1'b0, 1'b0}, 1'b1,
      '{ST_APPENDED, 1'b0, 1'b0, 4'd0, 4'd0, 9'd2}},
    '{'{FUNC_TOGGLE,   4'd15, 4'd15, 1'b0, 1'b0}, 1'b1,
      '{ST_REMOVED, 1'b0, 1'b0, 4'd0, 4'd0, 9'd1}},
    '{'{FUNC_TOGGLE,   4'd15, 4'd15, 1'b1, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_TOGGLE,   4'd3,  4'd10, 1'b0, 1'b1}, 1'b0, NO_WANT},
    '{'{FUNC_NEXT,     4'd0,  4'd0,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_CHECK,    4'd0,  4'd0,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_RESTART,  4'd0,  4'd0,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_CHECK,    4'd0,  4'd0,  1'b0, 1'b1}, 1'b0, NO_WANT},
    '{'{FUNC_CHECK,    4'd0,  4'd0,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_TOGGLE,   4'd15, 4'd15, 1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_CLEAR,    4'd0,  4'd0,  1'b0, 1'b0}, 1'b1,
      '{ST_NONE, 1'b1, 1'b0, 4'd0, 4'd0, 9'd0}},
    '{'{FUNC_TOGGLE,   4'd7,  4'd9,  1'b1, 1'b0}, 1'b1,
      '{ST_APPENDED, 1'b0, 1'b0, 4'd0, 4'd0, 9'd1}},
    '{'{FUNC_NEXT,     4'd0,  4'd0,  1'b0, 1'b0}, 1'b1,
      '{ST_NONE, 1'b0, 1'b1, 4'd7, 4'd9, 9'd1}},
    '{'{FUNC_CHECK,    4'd0,  4'd0,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_TOGGLE,   4'd7,  4'd9,  1'b0, 1'b0}, 1'b0, NO_WANT},
    '{'{FUNC_TOGGLE,   4'd10, 4'd5,  1'b0, 1'b0}, 1'b0, NO_WANT}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         func;
  logic [3:0]         album;
  logic [3:0]         track;
  logic               init;
  logic               ui_music_active;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         status;
  logic               stop_playback;
  logic               start_playback;
  logic [3:0]         play_album;
  logic [3:0]         play_track;
  logic [COUNT_W-1:0] entry_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  toggle_playlist_queue u_top (.*);

  // Playlist mirror
  entry_t queue_entries [LIST_DEPTH];
  int     queue_len;
  bit     song_on;
  bit     autoswitch_on;

  resp_t  pending_results [$];
  int     errors;
  int     words_sent;
  int     results_seen;
  int     peak_len;
  int     starts_seen;
  int     stops_seen;
  bit     src_gaps;
  bit     sink_stalls;
  bit     hold_output;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < queue_len; i++) queue_entries[i] = queue_entries[i + 1];
    queue_len--;
  endfunction

  // Move the head to the tail.
  function automatic void rotate_head();
    entry_t head;
    head = queue_entries[0];
    if (queue_len > 1) begin
      drop_entry(0);
      queue_entries[queue_len] = head;
      queue_len++;
    end
  endfunction

  function automatic bit check_wants_play(bit ui);
    if (ui || queue_len == 0 || song_on) return 1'b0;
    if (autoswitch_on) rotate_head();
    song_on = 1'b1;
    return 1'b1;
  endfunction

  function automatic resp_t playlist_step(cmd_t c);
    resp_t r;
    int    hit;
    r = '0;
    hit = -1;
    case (c.func)
      FUNC_TOGGLE: begin
        if (int'(c.album) < NUM_ALBUMS && int'(c.track) < NUM_TRACKS) begin
          for (int i = queue_len - 1; i >= 0; i--)
            if (queue_entries[i].album == c.album && queue_entries[i].track == c.track) hit = i;
          if (hit >= 0) begin
            if (hit == 0) begin
              song_on = 1'b0;
              r.stop = 1'b1;
            end
            drop_entry(hit);
            r.status = ST_REMOVED;
          end else if (queue_len >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            queue_entries[queue_len] = '{album: c.album, track: c.track};
            queue_len++;
            r.status = ST_APPENDED;
            if (!c.init) r.start = check_wants_play(c.ui);
          end
        end
      end
      FUNC_NEXT: begin
        if (queue_len > 0) begin
          rotate_head();
          r.start = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        queue_len = 0;
        song_on = 1'b0;
        r.stop = 1'b1;
      end
      FUNC_CHECK: r.start = check_wants_play(c.ui);
      FUNC_RESTART: song_on = 1'b0;
      default: ;
    endcase
    if (r.start) begin
      r.album = queue_entries[0].album;
      r.track = queue_entries[0].track;
    end
    r.count = COUNT_W'(queue_len);
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    int   sel;
    c.album = 4'($urandom);
    c.track = 4'($urandom);
    c.init = ($urandom_range(0, 9) < 3);
    c.ui = ($urandom_range(0, 9) < 2);
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    if (pick < 55) begin
      c.func = FUNC_TOGGLE;
      // Bias toward entries already queued, or a small set of pairs, so removals happen often.
      if (sel < 4 && queue_len > 0) begin
        {c.album, c.track} = queue_entries[(sel == 0) ? 0 : $urandom_range(0, queue_len - 1)];
      end else if (sel < 6) begin
        c.album = 4'($urandom_range(0, 1));
        c.track = 4'($urandom_range(0, 1));
      end
    end else if (pick < 68) begin
      c.func = FUNC_NEXT;
    end else if (pick < 81) begin
      c.func = FUNC_CHECK;
    end else if (pick < 90) begin
      c.func = FUNC_RESTART;
    end else if (pick < 94) begin
      c.func = FUNC_CLEAR;
    end else begin
      c.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed = 1'b0, input resp_t want = '0);
    resp_t r;
    int    gap;
    in_valid <= 1'b1;
    func <= c.func;
    album <= c.album;
    track <= c.track;
    init <= c.init;
    ui_music_active <= c.ui;
    do @(posedge clk); while (!in_ready);
    r = playlist_step(c);
    pending_results.push_back(typed ? want : r);
    words_sent++;
    if (queue_len > peak_len) peak_len = queue_len;
    if (src_gaps && $urandom_range(0, 9) < 3) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, drain all results and let the block go idle.
  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input bit value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AUTOSWITCH_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    autoswitch_on = value;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value)) begin
      $error("autoswitch readback: expected %0d, got %0d", value, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output sink with random back-pressure and one long hold-off on request.
  initial begin : sink
    int n;
    out_ready <= 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    resp_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d, entry_count %0d", status, entry_count);
        errors++;
      end else begin
        w = pending_results.pop_front();
        results_seen++;
        if (start_playback) starts_seen++;
        if (stop_playback) stops_seen++;
        if (status !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status);
          errors++;
        end
        if (stop_playback !== w.stop) begin
          $error("stop_playback: expected %0d, got %0d", w.stop, stop_playback);
          errors++;
        end
        if (start_playback !== w.start) begin
          $error("start_playback: expected %0d, got %0d", w.start, start_playback);
          errors++;
        end
        if (play_album !== w.album) begin
          $error("play_album: expected %0d, got %0d", w.album, play_album);
          errors++;
        end
        if (play_track !== w.track) begin
          $error("play_track: expected %0d, got %0d", w.track, play_track);
          errors++;
        end
        if (entry_count !== w.count) begin
          $error("entry_count: expected %0d, got %0d", w.count, entry_count);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    entry_t pairs [LIST_DEPTH];
    entry_t tmp;
    cmd_t   c;
    int     ph;
    int     n;
    int     j;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= FUNC_TOGGLE;
    album <= '0;
    track <= '0;
    init <= 1'b0;
    ui_music_active <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    queue_len = 0;
    song_on = 1'b0;
    autoswitch_on = 1'b0;
    errors = 0;
    words_sent = 0;
    results_seen = 0;
    peak_len = 0;
    starts_seen = 0;
    stops_seen = 0;
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    hold_output = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_write(1'b0);

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_cmd(DIRECTED[i].cmd, DIRECTED[i].typed, DIRECTED[i].want);

    ph = 0;
    while (words_sent < ITEM_TARGET) begin
      settle();
      cfg_write(ph % 2 == 0);
      src_gaps = 1'b1;
      sink_stalls = 1'b1;
      n = $urandom_range(150, 250);
      if (ph == 1) begin
        // Fill every (album, track) pair in random order, then churn the full list.
        for (int i = 0; i < LIST_DEPTH; i++) pairs[i] = entry_t'(8'(i));
        for (int i = LIST_DEPTH - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = pairs[i];
          pairs[i] = pairs[j];
          pairs[j] = tmp;
        end
        send_cmd('{FUNC_CLEAR, 4'd0, 4'd0, 1'b0, 1'b0});
        for (int i = 0; i < LIST_DEPTH; i++)
          send_cmd('{FUNC_TOGGLE, pairs[i].album, pairs[i].track,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))});
        n = 40;
      end else if (ph == 3) begin
        hold_output = 1'b1;
      end else if (ph == 4) begin
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
        c = random_cmd();
        send_cmd(c);
      end
      ph++;
    end

    settle();
    $display("run: %0d words over %0d phases, %0d results, peak list length %0d",
             words_sent, ph, results_seen, peak_len);
    $display("run: %0d playback starts, %0d stops, autoswitch on and off", starts_seen,
             stops_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/tpq_pkg.sv
hdl/tpq_cell.sv
hdl/tpq_chain.sv
hdl/toggle_playlist_queue.sv
tb/tb_toggle_playlist_queue.sv
